>>> rtl/rv32x_pkg.sv
// ---------------------------------------------------------------------------
// rv32x_pkg
// shared types and constants for the execute unit
// ---------------------------------------------------------------------------
package rv32x_pkg;

    localparam logic [6:0] OPC_R = 7'b0110011;
    localparam logic [6:0] OPC_I = 7'b0010011;
    localparam logic [6:0] OPC_L = 7'b0000011;
    localparam logic [6:0] OPC_S = 7'b0100011;
    localparam logic [6:0] OPC_B = 7'b1100011;

    localparam logic [3:0] ALU_ADD = 4'b0000;
    localparam logic [3:0] ALU_SUB = 4'b1000;
    localparam logic [3:0] ALU_SLL = 4'b0001;
    localparam logic [3:0] ALU_MUL = 4'b0010;
    localparam logic [3:0] ALU_DIV = 4'b0011;
    localparam logic [3:0] ALU_XOR = 4'b0100;
    localparam logic [3:0] ALU_SRL = 4'b0101;
    localparam logic [3:0] ALU_SRA = 4'b1101;
    localparam logic [3:0] ALU_OR  = 4'b0110;
    localparam logic [3:0] ALU_AND = 4'b0111;

    // funct3 values that allow the bit 30 variant
    localparam logic [2:0] F3_ADDSUB = 3'b000;
    localparam logic [2:0] F3_SHR    = 3'b101;

    localparam logic [2:0] F3_BEQ = 3'b000;
    localparam logic [2:0] F3_BNE = 3'b001;
    localparam logic [2:0] F3_BLT = 3'b100;
    localparam logic [2:0] F3_BGE = 3'b101;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OPC   = 2'd1;
    localparam logic [1:0] ST_ADDR  = 2'd2;
    localparam logic [1:0] ST_FUNCT = 2'd3;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [15:0] instr_index;
    } t_in;

    typedef struct packed {
        logic [15:0] next_index;
        logic        branch_taken;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic        mem_written;
        logic [4:0]  mem_addr;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_DIV, S_MEM, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/rv32x_divider.sv
// ---------------------------------------------------------------------------
// rv32x_divider
// signed truncating divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rv32x_divider
    import rv32x_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [31:0] r_fix, n_fix;
    logic        r_use_fix, n_use_fix;
    logic [32:0] w_trial;
    logic [31:0] w_shift;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_done = 1'b0;
        n_fix = r_fix; n_use_fix = r_use_fix;
        w_shift = {r_rem[30:0], r_quo[31]};
        w_trial = {1'b0, w_shift} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem = '0;
            n_quo = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            n_den = i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            n_neg = i_req.dividend[31] ^ i_req.divisor[31];
            n_cnt = 6'd32;
            n_busy = 1'b1;
            // special cases: divide by zero and the one overflow
            n_use_fix = 1'b0;
            n_fix = '0;
            if (i_req.divisor == 32'd0) begin
                n_use_fix = 1'b1;
                n_fix = '1;
            end else if (i_req.dividend == 32'h8000_0000 && i_req.divisor == '1) begin
                n_use_fix = 1'b1;
                n_fix = i_req.dividend;
            end
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
        r_fix <= n_fix;
        r_use_fix <= n_use_fix;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_use_fix ? r_fix : (r_neg ? (32'd0 - r_quo) : r_quo);

endmodule

>>> rtl/rv32x_regfile.sv
// ---------------------------------------------------------------------------
// rv32x_regfile
// 32 x 32 register file, two registered read ports, valid bits for reset
// ---------------------------------------------------------------------------
module rv32x_regfile
    import rv32x_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata
);

    logic [31:0] mem_a [32];
    logic [31:0] mem_b [32];
    logic [31:0] r_valid;
    logic [31:0] r_qa, r_qb;
    logic        r_va, r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_a[i_waddr] <= i_wdata;
            mem_b[i_waddr] <= i_wdata;
        end
        r_qa <= mem_a[i_raddr_a];
        r_qb <= mem_b[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= 1'b1;
            r_va <= r_valid[i_raddr_a] && (i_raddr_a != 5'd0);
            r_vb <= r_valid[i_raddr_b] && (i_raddr_b != 5'd0);
        end
    end

    assign o_rdata_a = r_va ? r_qa : '0;
    assign o_rdata_b = r_vb ? r_qb : '0;

endmodule

>>> rtl/rv32_subset_execute_unit.sv
// ---------------------------------------------------------------------------
// rv32_subset_execute_unit
// executes one rv32-style instruction per input beat, in program order
// ---------------------------------------------------------------------------
// one instruction at a time: accept, read the register file (registered
// read), execute, then for loads read data memory (registered read), and
// finally hold the result beat in an output register. a divide waits for
// the one-bit-per-cycle divider. the register file and data memory are
// synchronous rams; the register file reads as zero through valid bits,
// and after reset the data memory is cleared one word per cycle, so the
// input stalls until the clear is done before the first beat is taken. any
// instruction ending with a nonzero status writes no state.
module rv32_subset_execute_unit
    import rv32x_pkg::*;
#(
    parameter int DMEM_WORDS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic [31:0] r_val, n_val;
    logic [AW-1:0] r_ea;
    logic   accept;

    // instruction fields
    logic [31:0] w;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        b30;
    logic [31:0] imm_i, imm_s;
    assign w     = r_in.instr_word;
    assign opc   = w[6:0];
    assign rd    = w[11:7];
    assign f3    = w[14:12];
    assign b30   = w[30];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};

    // register file, addressed from the incoming beat while idle and from
    // the held instruction afterwards
    logic [31:0] rs_a, rs_b;
    logic        rf_we;
    logic [31:0] rf_wdata;
    logic [4:0]  rf_ra, rf_rb;
    assign rf_ra = (r_state == S_IDLE) ? i_data.instr_word[19:15] : w[19:15];
    assign rf_rb = (r_state == S_IDLE) ? i_data.instr_word[24:20] : w[24:20];
    rv32x_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_raddr_a(rf_ra),
        .i_raddr_b(rf_rb),
        .o_rdata_a(rs_a), .o_rdata_b(rs_b),
        .i_we(rf_we), .i_waddr(rd), .i_wdata(rf_wdata)
    );

    // data memory, cleared word by word after reset
    logic [31:0] dmem [DMEM_WORDS];
    logic [31:0] r_dq;
    logic        dm_we;
    logic [AW-1:0] dm_addr;
    logic        r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) dmem[r_clr_addr] <= '0;
        else if (dm_we) dmem[dm_addr] <= rs_b;
        r_dq <= dmem[dm_addr];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DMEM_WORDS - 1)) r_clr_busy <= 1'b0;
        end
    end

    // divider
    t_div_req div_req;
    t_div_rsp div_rsp;
    rv32x_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // alu operands and code
    logic [31:0] op_b;
    logic [3:0]  code;
    logic [31:0] alu_res;
    logic [4:0]  sh;
    logic [31:0] ea;
    logic [INDEX_BITS-1:0] idx, nxt_seq, nxt_br;
    logic        cond;

    assign op_b = (opc == OPC_R) ? rs_b : imm_i;
    assign sh   = op_b[4:0];
    assign ea   = rs_a + ((opc == OPC_L) ? imm_i : imm_s);
    assign idx  = INDEX_BITS'(r_in.instr_index);
    assign nxt_seq = idx + INDEX_BITS'(1);
    assign nxt_br  = idx + INDEX_BITS'(imm_s);
    assign dm_addr = (r_state == S_EXEC) ? ea[AW-1:0] : r_ea;

    always_comb begin
        if (opc == OPC_R) code = {b30, f3};
        else code = (f3 == F3_SHR && b30) ? ALU_SRA : {1'b0, f3};
    end

    always_comb begin
        case (code)
            ALU_ADD: alu_res = rs_a + op_b;
            ALU_SUB: alu_res = rs_a - op_b;
            ALU_SLL: alu_res = rs_a << sh;
            ALU_MUL: alu_res = rs_a * op_b;
            ALU_XOR: alu_res = rs_a ^ op_b;
            ALU_SRL: alu_res = rs_a >> sh;
            ALU_SRA: alu_res = $unsigned($signed(rs_a) >>> sh);
            ALU_OR:  alu_res = rs_a | op_b;
            ALU_AND: alu_res = rs_a & op_b;
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        case (f3)
            F3_BEQ:  cond = (rs_a == rs_b);
            F3_BNE:  cond = (rs_a != rs_b);
            F3_BLT:  cond = $signed(rs_a) < $signed(rs_b);
            F3_BGE:  cond = !($signed(rs_a) < $signed(rs_b));
            default: cond = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_out = r_out;
        n_val = r_val;
        rf_we = 1'b0;
        rf_wdata = r_val;
        dm_we = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = rs_a;
        div_req.divisor = op_b;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                n_out = '0;
                n_out.next_index = 16'(nxt_seq);
                n_state = S_OUT;
                if (opc == OPC_R || opc == OPC_I) begin
                    if (opc == OPC_R && b30 && f3 != F3_ADDSUB && f3 != F3_SHR) begin
                        n_out.status = ST_FUNCT;
                    end else if (code == ALU_DIV) begin
                        div_req.start = 1'b1;
                        n_state = S_DIV;
                    end else if (rd != 5'd0) begin
                        rf_we = 1'b1;
                        rf_wdata = alu_res;
                        n_out.reg_written = 1'b1;
                        n_out.dest_reg = rd;
                        n_out.write_value = alu_res;
                    end
                end else if (opc == OPC_L || opc == OPC_S) begin
                    n_out.mem_addr = ea[4:0];
                    if (ea >= 32'(DMEM_WORDS)) begin
                        n_out.status = ST_ADDR;
                    end else if (opc == OPC_L) begin
                        n_state = S_MEM;
                    end else begin
                        dm_we = 1'b1;
                        n_out.mem_written = 1'b1;
                    end
                end else if (opc == OPC_B) begin
                    if (cond) begin
                        n_out.branch_taken = 1'b1;
                        n_out.next_index = 16'(nxt_br);
                    end
                end else begin
                    n_out.status = ST_OPC;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                    if (rd != 5'd0) begin
                        rf_we = 1'b1;
                        rf_wdata = div_rsp.quotient;
                        n_out.reg_written = 1'b1;
                        n_out.dest_reg = rd;
                        n_out.write_value = div_rsp.quotient;
                    end
                end
            end
            S_MEM: begin
                // registered data memory read is ready here
                n_val = r_dq;
                n_state = S_OUT;
                if (rd != 5'd0) begin
                    rf_we = 1'b1;
                    rf_wdata = n_val;
                    n_out.reg_written = 1'b1;
                    n_out.dest_reg = rd;
                    n_out.write_value = n_val;
                end
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (accept) r_in <= i_data;
        if (r_state == S_EXEC) r_ea <= ea[AW-1:0];
        r_out <= n_out;
        r_val <= n_val;
    end

    // input taken only while idle and after the memory clear; the register
    // file read starts on accept
    assign o_stall = (r_state != S_IDLE) || r_clr_busy;
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

endmodule
